[hw/rtl/awf_pkg.sv]
// ----------------------------------------------------------------------------
// awf_pkg
// shared types, constants and byte helpers for the anagram word filter
// ----------------------------------------------------------------------------
`default_nettype none

package awf_pkg;

   localparam int ByteWidth     = 8;
   localparam int QueryBytes    = 16;
   localparam int PosWidth      = 4;
   localparam int LenWidth      = 5;
   localparam int TotalWidth    = 16;
   localparam int CsrDataWidth  = 64;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrQueryLow  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrQueryHigh = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrQueryLen  = 2'd2;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef struct packed {
      logic [QueryBytes-1:0][ByteWidth-1:0] bytes;
      logic [LenWidth-1:0]                  length;
   } query_type;

   typedef struct packed {
      byte_type code;
      logic     present;
      logic     end_of_word;
   } item_type;

   function automatic byte_type fold_byte(input byte_type b);
      byte_type r;
      r = b;
      if (b >= 8'd65 && b <= 8'd90) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_blank(input byte_type b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/awf_query_regs.sv]
// ----------------------------------------------------------------------------
// awf_query_regs
// query registers, stored already folded to lower case
// ----------------------------------------------------------------------------
`default_nettype none

module awf_query_regs (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [awf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire  [awf_pkg::CsrDataWidth-1:0]    csr_write_data,
   output awf_pkg::query_type                  query,
   output logic                                count_clear
);

   localparam int HalfBytes = awf_pkg::QueryBytes / 2;

   logic [awf_pkg::QueryBytes-1:0][awf_pkg::ByteWidth-1:0] bytes_ff;
   logic [awf_pkg::LenWidth-1:0]                           length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff  <= '0;
         length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            awf_pkg::CsrQueryLow: begin
               for (int i = 0; i < HalfBytes; i++) begin
                  bytes_ff[i] <= awf_pkg::fold_byte(csr_write_data[i*8 +: 8]);
               end
            end
            awf_pkg::CsrQueryHigh: begin
               for (int i = 0; i < HalfBytes; i++) begin
                  bytes_ff[HalfBytes+i] <= awf_pkg::fold_byte(csr_write_data[i*8 +: 8]);
               end
            end
            awf_pkg::CsrQueryLen: begin
               length_ff <= csr_write_data[awf_pkg::LenWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // any write to a known register restarts the anagram count
   always_comb begin
      count_clear = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            awf_pkg::CsrQueryLow:  count_clear = 1'b1;
            awf_pkg::CsrQueryHigh: count_clear = 1'b1;
            awf_pkg::CsrQueryLen:  count_clear = 1'b1;
            default:               count_clear = 1'b0;
         endcase
      end
   end

   assign query.bytes  = bytes_ff;
   assign query.length = length_ff;

endmodule

`default_nettype wire

[hw/rtl/awf_word_state.sv]
// ----------------------------------------------------------------------------
// awf_word_state
// per-word claim tracking and end-of-word anagram decision
// ----------------------------------------------------------------------------
`default_nettype none

module awf_word_state #(
   parameter int MAX_WORD_LEN = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  awf_pkg::query_type query,
   input  awf_pkg::item_type  item,
   input  wire                advance,
   output logic               hit
);

   localparam int KeptWidth = $clog2(MAX_WORD_LEN + 2);
   localparam logic [KeptWidth-1:0] KeptMax = KeptWidth'(MAX_WORD_LEN + 1);

   logic [awf_pkg::QueryBytes-1:0] claimed_ff, claimed_in;
   logic [KeptWidth-1:0]           kept_ff, kept_in;
   logic                           mismatch_ff, mismatch_in;
   logic                           differs_ff, differs_in;

   awf_pkg::byte_type              folded;
   logic                           take;
   logic [awf_pkg::LenWidth-1:0]   kept_ext;
   logic [awf_pkg::LenWidth-1:0]   kept_next_ext;
   logic [awf_pkg::QueryBytes-1:0] free_eq;
   logic [awf_pkg::QueryBytes-1:0] pick;

   assign folded   = awf_pkg::fold_byte(item.code);
   assign take     = item.present && !awf_pkg::is_blank(item.code);
   assign kept_ext = awf_pkg::LenWidth'(kept_ff);

   // unclaimed positions inside the query length holding this byte
   always_comb begin
      for (int p = 0; p < awf_pkg::QueryBytes; p++) begin
         free_eq[p] = !claimed_ff[p] && (query.bytes[p] == folded) &&
                      (awf_pkg::LenWidth'(p) < query.length);
      end
   end

   // lowest set bit wins
   assign pick = free_eq & (~free_eq + awf_pkg::QueryBytes'(1));

   always_comb begin
      claimed_in  = claimed_ff;
      kept_in     = kept_ff;
      mismatch_in = mismatch_ff;
      differs_in  = differs_ff;
      if (take) begin
         if (kept_ext < awf_pkg::LenWidth'(awf_pkg::QueryBytes) &&
             query.bytes[kept_ext[awf_pkg::PosWidth-1:0]] != folded) begin
            differs_in = 1'b1;
         end
         claimed_in = claimed_ff | pick;
         if (free_eq == '0) begin
            mismatch_in = 1'b1;
         end
         if (kept_ff < KeptMax) begin
            kept_in = kept_ff + KeptWidth'(1);
         end
      end
   end

   assign kept_next_ext = awf_pkg::LenWidth'(kept_in);
   assign hit = !mismatch_in && differs_in &&
                (query.length <= awf_pkg::LenWidth'(MAX_WORD_LEN)) &&
                (kept_next_ext == query.length);

   always_ff @(posedge clock) begin
      if (reset) begin
         claimed_ff  <= '0;
         kept_ff     <= '0;
         mismatch_ff <= 1'b0;
         differs_ff  <= 1'b0;
      end else if (advance) begin
         if (item.end_of_word) begin
            claimed_ff  <= '0;
            kept_ff     <= '0;
            mismatch_ff <= 1'b0;
            differs_ff  <= 1'b0;
         end else begin
            claimed_ff  <= claimed_in;
            kept_ff     <= kept_in;
            mismatch_ff <= mismatch_in;
            differs_ff  <= differs_in;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/anagram_word_filter_core.sv]
// ----------------------------------------------------------------------------
// anagram_word_filter_core
// streams dictionary words one byte at a time and flags anagrams of a query
// ----------------------------------------------------------------------------
// usage:
//   load the query through the csr port (index 0 low bytes, 1 high bytes,
//   2 length) while the block is idle; any such write clears the count
//   send one byte per req word; end_of_word marks the last word of an entry,
//   char_present low carries no byte (an empty line end)
//   every word with end_of_word gives one rsp word: is_anagram and the
//   running anagram count, saturating at its maximum; other words give none
// timing:
//   a req word is held in the input register and evaluated there; its result
//   is then registered in the result register and shown on rsp
//   one req word per cycle while req_stall is low: the claim is a parallel
//   compare and a priority pick over the sixteen query positions, combinational
// reset (synchronous, active high) empties both registers, the word state
// and the count, and zeroes the query
// when rsp is stalled the result register holds; a non-final byte still
// moves through, and a final byte waits in the input register, which in
// turn raises req_stall
// ----------------------------------------------------------------------------
`default_nettype none

module anagram_word_filter_core #(
   parameter int MAX_WORD_LEN = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [7:0]                         req_char_code,
   input  wire                                req_char_present,
   input  wire                                req_end_of_word,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_is_anagram,
   output logic [15:0]                        rsp_anagram_total,
   // configuration
   input  wire                                csr_write_enable,
   input  wire  [awf_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire  [awf_pkg::CsrDataWidth-1:0]   csr_write_data
);

   localparam logic [awf_pkg::TotalWidth-1:0] TotalMax = '1;

   awf_pkg::query_type query;
   logic               count_clear;

   // input register
   logic               in_valid_ff, in_valid_in;
   awf_pkg::item_type  item_ff;

   // result register and running count
   logic                            out_valid_ff, out_valid_in;
   logic                            out_hit_ff;
   logic [awf_pkg::TotalWidth-1:0]  total_ff, total_in;

   logic req_accept;
   logic out_free;
   logic advance;
   logic hit;

   awf_query_regs u_query (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .query            (query),
      .count_clear      (count_clear)
   );

   awf_word_state #(
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .query   (query),
      .item    (item_ff),
      .advance (advance),
      .hit     (hit)
   );

   // result register can take a new result when empty or being drained
   assign out_free = !out_valid_ff || !rsp_stall;
   // only a final byte needs room in the result register
   assign advance  = in_valid_ff && (!item_ff.end_of_word || out_free);

   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.code        <= req_char_code;
         item_ff.present     <= req_char_present;
         item_ff.end_of_word <= req_end_of_word;
      end
   end

   // count update on a finished word, saturating; a query write clears it
   always_comb begin
      total_in = total_ff;
      if (count_clear) begin
         total_in = '0;
      end else if (advance && item_ff.end_of_word && hit && total_ff != TotalMax) begin
         total_in = total_ff + awf_pkg::TotalWidth'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && item_ff.end_of_word) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_ff.end_of_word) begin
         out_hit_ff <= hit;
      end
   end

   // the count register holds the value just reported until the next final byte or a query write
   assign rsp_valid         = out_valid_ff;
   assign rsp_is_anagram    = out_hit_ff;
   assign rsp_anagram_total = total_ff;

endmodule

`default_nettype wire
